// File: rtl/sss_pkg.sv
package sss_pkg;

  // set size bound and derived widths
  localparam int MAX_POINTS = 1024;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int VAL_W   = 24;
  localparam int SD_W    = 23;
  localparam int PT_W    = 11;

  localparam int SUM_W   = VAL_W + CNT_W - 1;
  localparam int SQ_W    = 2 * VAL_W - 1;
  localparam int SUMSQ_W = SQ_W + CNT_W;
  localparam int MSQ_W   = 2 * VAL_W;

  // shared divider and square root widths
  localparam int DIV_W   = SUMSQ_W;
  localparam int RT_W    = (DIV_W + 1) / 2;
  localparam int SQV_W   = 2 * RT_W;
  localparam int REM_W   = RT_W + 2;
  localparam int STEP_W  = $clog2(DIV_W);

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [SD_W-1:0]         SD_MAX  = {SD_W{1'b1}};

  typedef struct packed {
    logic acc;
    logic div_ld_mean;
    logic div_ld_ms;
    logic div_step;
    logic sqrt_ld;
    logic sqrt_step;
    logic out_ld;
  } sss_cmd_t;

endpackage

// File: rtl/sss_ctrl.sv
module sss_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last_point,
  input  logic             out_stall,
  output logic             in_stall,
  output logic             out_valid,
  output sss_pkg::sss_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_DIV_MEAN,
    ST_LD_MS,
    ST_DIV_MS,
    ST_SQ_LD,
    ST_SQRT,
    ST_DONE
  } state_t;

  state_t                     state_r, state_nxt;
  logic [sss_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        cmd.acc = in_valid;
        if (in_valid && in_last_point) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // sum of y and count are final here; squares land this cycle
        cmd.div_ld_mean = 1'b1;
        step_nxt        = sss_pkg::STEP_W'(sss_pkg::DIV_W - 1);
        state_nxt       = ST_DIV_MEAN;
      end
      ST_DIV_MEAN: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_LD_MS;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_LD_MS: begin
        cmd.div_ld_ms = 1'b1;
        step_nxt      = sss_pkg::STEP_W'(sss_pkg::DIV_W - 1);
        state_nxt     = ST_DIV_MS;
      end
      ST_DIV_MS: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_SQ_LD;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_SQ_LD: begin
        cmd.sqrt_ld = 1'b1;
        step_nxt    = sss_pkg::STEP_W'(sss_pkg::RT_W - 1);
        state_nxt   = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/sss_dp.sv
module sss_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sss_pkg::sss_cmd_t                 cmd,
  input  logic signed [sss_pkg::VAL_W-1:0]  in_x_value,
  input  logic signed [sss_pkg::VAL_W-1:0]  in_y_value,
  output logic signed [sss_pkg::VAL_W-1:0]  out_min_x_out,
  output logic signed [sss_pkg::VAL_W-1:0]  out_max_x_out,
  output logic signed [sss_pkg::VAL_W-1:0]  out_min_y_out,
  output logic signed [sss_pkg::VAL_W-1:0]  out_max_y_out,
  output logic signed [sss_pkg::VAL_W-1:0]  out_mean_y_out,
  output logic [sss_pkg::SD_W-1:0]          out_stddev_y_out,
  output logic [sss_pkg::PT_W-1:0]          out_point_count,
  output logic                              out_count_overflow
);

  // accumulators
  logic signed [sss_pkg::VAL_W-1:0]  min_x_r, max_x_r, min_y_r, max_y_r;
  logic [sss_pkg::CNT_W-1:0]         cnt_r;
  logic signed [sss_pkg::SUM_W-1:0]  sum_r;
  logic [sss_pkg::SUMSQ_W-1:0]       sumsq_r;
  logic                              ovf_r;
  logic [sss_pkg::SQ_W-1:0]          sq_r;
  logic                              sq_vld_r;

  // divider, mean, square root
  logic [sss_pkg::DIV_W-1:0]         div_q_r;
  logic [sss_pkg::CNT_W-1:0]         div_rem_r;
  logic [sss_pkg::VAL_W-1:0]         qm_r;
  logic [sss_pkg::MSQ_W-1:0]         msq_r;
  logic [sss_pkg::SQV_W-1:0]         sqv_r;
  logic [sss_pkg::REM_W-1:0]         sq_rem_r;
  logic [sss_pkg::RT_W-1:0]          root_r;

  logic                              take;
  logic signed [2*sss_pkg::VAL_W-1:0] y_prod;
  logic [sss_pkg::CNT_W-1:0]         n_eff;
  logic [sss_pkg::SUM_W-1:0]         mag;
  logic [sss_pkg::DIV_W-1:0]         mean_dvd;
  logic [sss_pkg::CNT_W:0]           div_sh;
  logic                              div_ge;
  logic [sss_pkg::DIV_W-1:0]         var_v;
  logic [sss_pkg::REM_W+1:0]         sq_sh;
  logic [sss_pkg::REM_W+1:0]         sq_trial;
  logic                              sq_ge;
  logic [sss_pkg::VAL_W-1:0]         mean_v;
  logic [sss_pkg::SD_W-1:0]          sd_v;

  assign take   = (cnt_r < sss_pkg::CNT_W'(sss_pkg::MAX_POINTS));
  assign y_prod = in_y_value * in_y_value;

  assign n_eff    = (cnt_r == '0) ? sss_pkg::CNT_W'(1) : cnt_r;
  assign mag      = sum_r[sss_pkg::SUM_W-1] ? sss_pkg::SUM_W'(-sum_r)
                                             : sss_pkg::SUM_W'(sum_r);
  assign mean_dvd = sss_pkg::DIV_W'(mag) + sss_pkg::DIV_W'(n_eff >> 1);

  // restoring division, one quotient bit per step
  assign div_sh = {div_rem_r, div_q_r[sss_pkg::DIV_W-1]};
  assign div_ge = (div_sh >= {1'b0, n_eff});

  // div_q_r holds sumsq / n once the second division is over
  assign var_v = (div_q_r > sss_pkg::DIV_W'(msq_r))
               ? div_q_r - sss_pkg::DIV_W'(msq_r) : '0;

  // square root, two radicand bits per step
  assign sq_sh    = {sq_rem_r, sqv_r[sss_pkg::SQV_W-1 -: 2]};
  assign sq_trial = (sss_pkg::REM_W+2)'({root_r, 2'b01});
  assign sq_ge    = (sq_sh >= sq_trial);

  assign mean_v = sum_r[sss_pkg::SUM_W-1] ? (~qm_r + 1'b1) : qm_r;
  assign sd_v   = (root_r > sss_pkg::RT_W'(sss_pkg::SD_MAX)) ? sss_pkg::SD_MAX
                                                            : sss_pkg::SD_W'(root_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r  <= sss_pkg::VAL_MAX;
      max_x_r  <= sss_pkg::VAL_MIN;
      min_y_r  <= sss_pkg::VAL_MAX;
      max_y_r  <= sss_pkg::VAL_MIN;
      cnt_r    <= '0;
      sum_r    <= '0;
      sumsq_r  <= '0;
      ovf_r    <= 1'b0;
      sq_vld_r <= 1'b0;
    end else begin
      sq_vld_r <= cmd.acc && take;
      if (sq_vld_r) begin
        sumsq_r <= sumsq_r + sss_pkg::SUMSQ_W'(sq_r);
      end
      if (cmd.acc) begin
        if (take) begin
          cnt_r <= cnt_r + 1'b1;
          sum_r <= sum_r + sss_pkg::SUM_W'(in_y_value);
          if (in_x_value < min_x_r) min_x_r <= in_x_value;
          if (in_x_value > max_x_r) max_x_r <= in_x_value;
          if (in_y_value < min_y_r) min_y_r <= in_y_value;
          if (in_y_value > max_y_r) max_y_r <= in_y_value;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.out_ld) begin
        min_x_r <= sss_pkg::VAL_MAX;
        max_x_r <= sss_pkg::VAL_MIN;
        min_y_r <= sss_pkg::VAL_MAX;
        max_y_r <= sss_pkg::VAL_MIN;
        cnt_r   <= '0;
        sum_r   <= '0;
        sumsq_r <= '0;
        ovf_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sq_r  <= y_prod[sss_pkg::SQ_W-1:0];
    msq_r <= qm_r * qm_r;

    if (cmd.div_ld_mean) begin
      div_q_r   <= mean_dvd;
      div_rem_r <= '0;
    end else if (cmd.div_ld_ms) begin
      div_q_r   <= sss_pkg::DIV_W'(sumsq_r);
      div_rem_r <= '0;
      qm_r      <= div_q_r[sss_pkg::VAL_W-1:0];
    end else if (cmd.div_step) begin
      div_q_r   <= {div_q_r[sss_pkg::DIV_W-2:0], div_ge};
      div_rem_r <= div_ge ? sss_pkg::CNT_W'(div_sh - {1'b0, n_eff})
                          : sss_pkg::CNT_W'(div_sh);
    end

    if (cmd.sqrt_ld) begin
      sqv_r    <= sss_pkg::SQV_W'(var_v);
      sq_rem_r <= '0;
      root_r   <= '0;
    end else if (cmd.sqrt_step) begin
      sqv_r    <= {sqv_r[sss_pkg::SQV_W-3:0], 2'b00};
      sq_rem_r <= sq_ge ? sss_pkg::REM_W'(sq_sh - sq_trial) : sss_pkg::REM_W'(sq_sh);
      root_r   <= {root_r[sss_pkg::RT_W-2:0], sq_ge};
    end

    if (cmd.out_ld) begin
      out_min_x_out      <= min_x_r;
      out_max_x_out      <= max_x_r;
      out_min_y_out      <= min_y_r;
      out_max_y_out      <= max_y_r;
      out_mean_y_out     <= mean_v;
      out_stddev_y_out   <= sd_v;
      out_point_count    <= sss_pkg::PT_W'(cnt_r);
      out_count_overflow <= ovf_r;
    end
  end

endmodule

// File: rtl/sample_set_statistics_unit.sv
// Input: a point that is not last is taken in the cycle it is offered; after the last
//   point of a set, the divider and then the square root run before the result appears.
// Throughput: one point per cycle while accumulating; the divider (58 steps,
//   used twice) and the square root (29 steps) keep the input stalled after
//   each set, longer while an earlier result still waits downstream.
// Reset: synchronous, active low; empties the set and drops any pending result.
module sample_set_statistics_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // point input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [sss_pkg::VAL_W-1:0] in_x_value,
  input  logic signed [sss_pkg::VAL_W-1:0] in_y_value,
  input  logic                             in_last_point,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [sss_pkg::VAL_W-1:0] out_min_x_out,
  output logic signed [sss_pkg::VAL_W-1:0] out_max_x_out,
  output logic signed [sss_pkg::VAL_W-1:0] out_min_y_out,
  output logic signed [sss_pkg::VAL_W-1:0] out_max_y_out,
  output logic signed [sss_pkg::VAL_W-1:0] out_mean_y_out,
  output logic [sss_pkg::SD_W-1:0]         out_stddev_y_out,
  output logic [sss_pkg::PT_W-1:0]         out_point_count,
  output logic                             out_count_overflow
);

  // Point path: each accepted beat updates the extremes, the count and the
  // sum of y at once; y*y is registered and folded into the sum of squares in
  // the next cycle. A point beyond the set bound is dropped and flags overflow.
  //
  // Close of set (last point): the shared restoring divider first forms the
  // rounded mean magnitude (|sum| + n/2) / n, then sum of squares / n. The
  // mean square is subtracted (clamped at zero) and the digit-by-digit root
  // yields the deviation, saturated to the output width.
  //
  // The result lands in an output register and the accumulators clear on the
  // same edge, so the next set may stream in while the beat waits downstream.

  sss_pkg::sss_cmd_t cmd;

  sss_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_point (in_last_point),
    .out_stall     (out_stall),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .cmd           (cmd)
  );

  sss_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_x_value         (in_x_value),
    .in_y_value         (in_y_value),
    .out_min_x_out      (out_min_x_out),
    .out_max_x_out      (out_max_x_out),
    .out_min_y_out      (out_min_y_out),
    .out_max_y_out      (out_max_y_out),
    .out_mean_y_out     (out_mean_y_out),
    .out_stddev_y_out   (out_stddev_y_out),
    .out_point_count    (out_point_count),
    .out_count_overflow (out_count_overflow)
  );

endmodule
